// ----- hdl/xrle_pkg.sv -----
// ----------------------------------------------------------------------------
// xrle_pkg
// Shared types and constants of the run-length pair decoder.
// ----------------------------------------------------------------------------
package xrle_pkg;

	localparam int unsigned PAIRS_W     = 24;
	localparam int unsigned RUN_LEN_W   = 6;
	localparam int unsigned COUNT_W     = RUN_LEN_W + 1;
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

	localparam logic [PAIRS_W-1:0] TOTAL_PAIRS_RESET = PAIRS_W'(2000);

	// run mode from the top two bits of a header byte
	typedef enum logic [1:0] {
		MODE_RAW,
		MODE_REP_CHAR,
		MODE_REP_ATTR,
		MODE_REP_BOTH
	} mode_t;

	// one command from the parser: emit count pairs of (char, attr)
	typedef struct packed {
		logic [7:0]         char_code;
		logic [7:0]         attribute;
		logic [COUNT_W-1:0] count;
		logic               run_end;
	} cmd_t;

endpackage

// ----- hdl/xrle_front.sv -----
// ----------------------------------------------------------------------------
// xrle_front
// Stream parser: walks header, repeat and literal bytes and turns every byte
// that yields pairs into one command for the emitter.
// ----------------------------------------------------------------------------
module xrle_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         data_byte,
	input  logic               q_full,
	output logic               q_push,
	output xrle_pkg::cmd_t     q_cmd
);

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_REP_CHAR,
		PH_REP_ATTR,
		PH_LIT_CHAR,
		PH_LIT_ATTR
	} phase_t;

	phase_t                            phase_q;
	xrle_pkg::mode_t                   mode_q;
	logic [xrle_pkg::COUNT_W-1:0]      remaining_q;
	logic [7:0]                        held_char_q;
	logic [7:0]                        held_attr_q;
	logic                              take;
	logic                              run_done;

	assign in_ready = !q_full;
	assign take     = in_valid && in_ready;
	assign run_done = (remaining_q <= xrle_pkg::COUNT_W'(1));

	always_comb begin
		q_push = 1'b0;
		q_cmd  = '{char_code: held_char_q, attribute: held_attr_q,
		           count: xrle_pkg::COUNT_W'(1), run_end: run_done};
		unique case (phase_q)
			PH_REP_ATTR: begin
				q_cmd.attribute = data_byte;
				q_cmd.count     = remaining_q;
				q_cmd.run_end   = 1'b1;
				q_push          = take && (mode_q == xrle_pkg::MODE_REP_BOTH);
			end
			PH_LIT_CHAR: begin
				q_cmd.char_code = data_byte;
				q_push          = take && (mode_q != xrle_pkg::MODE_RAW);
			end
			PH_LIT_ATTR: begin
				q_cmd.attribute = data_byte;
				q_push          = take;
			end
			default: begin
				q_push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HEADER;
			mode_q      <= xrle_pkg::MODE_RAW;
			remaining_q <= '0;
			held_char_q <= '0;
			held_attr_q <= '0;
		end else if (take) begin
			unique case (phase_q)
				PH_HEADER: begin
					mode_q      <= xrle_pkg::mode_t'(data_byte[7:6]);
					remaining_q <= {1'b0, data_byte[xrle_pkg::RUN_LEN_W-1:0]}
					               + xrle_pkg::COUNT_W'(1);
					unique case (xrle_pkg::mode_t'(data_byte[7:6]))
						xrle_pkg::MODE_RAW:      phase_q <= PH_LIT_CHAR;
						xrle_pkg::MODE_REP_ATTR: phase_q <= PH_REP_ATTR;
						default:                 phase_q <= PH_REP_CHAR;
					endcase
				end
				PH_REP_CHAR: begin
					held_char_q <= data_byte;
					phase_q     <= (mode_q == xrle_pkg::MODE_REP_BOTH)
					               ? PH_REP_ATTR : PH_LIT_ATTR;
				end
				PH_REP_ATTR: begin
					held_attr_q <= data_byte;
					if (mode_q == xrle_pkg::MODE_REP_BOTH) begin
						remaining_q <= '0;
						phase_q     <= PH_HEADER;
					end else begin
						phase_q <= PH_LIT_CHAR;
					end
				end
				PH_LIT_CHAR: begin
					if (mode_q == xrle_pkg::MODE_RAW) begin
						held_char_q <= data_byte;
						phase_q     <= PH_LIT_ATTR;
					end else begin
						if (remaining_q != '0) remaining_q <= remaining_q - 1'b1;
						phase_q <= run_done ? PH_HEADER : PH_LIT_CHAR;
					end
				end
				PH_LIT_ATTR: begin
					if (remaining_q != '0) remaining_q <= remaining_q - 1'b1;
					priority if (run_done)                    phase_q <= PH_HEADER;
					else if (mode_q == xrle_pkg::MODE_RAW)    phase_q <= PH_LIT_CHAR;
					else                                      phase_q <= PH_LIT_ATTR;
				end
				default: begin
					phase_q <= PH_HEADER;
				end
			endcase
		end
	end

endmodule

// ----- hdl/xrle_queue.sv -----
// ----------------------------------------------------------------------------
// xrle_queue
// Small command queue between the parser and the pair emitter.
// ----------------------------------------------------------------------------
module xrle_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  xrle_pkg::cmd_t     push_cmd,
	input  logic               pop,
	output xrle_pkg::cmd_t     pop_cmd,
	output logic               full,
	output logic               empty
);

	xrle_pkg::cmd_t                    mem_q [xrle_pkg::QUEUE_DEPTH];
	logic [xrle_pkg::QUEUE_AW-1:0]     wr_ptr_q;
	logic [xrle_pkg::QUEUE_AW-1:0]     rd_ptr_q;
	logic [xrle_pkg::QUEUE_AW:0]       fill_q;

	assign full    = (fill_q == (xrle_pkg::QUEUE_AW+1)'(xrle_pkg::QUEUE_DEPTH));
	assign empty   = (fill_q == '0);
	assign pop_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			unique case ({push, pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

// ----- hdl/xrle_back.sv -----
// ----------------------------------------------------------------------------
// xrle_back
// Pair emitter: runs queued commands one pair per cycle while out_ready
// allows, counts pairs against the image size and drops what overflows it.
// ----------------------------------------------------------------------------
module xrle_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_empty,
	input  xrle_pkg::cmd_t                q_cmd,
	output logic                          q_pop,
	input  logic [xrle_pkg::PAIRS_W-1:0]  total_pairs,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [7:0]                    char_code,
	output logic [7:0]                    attribute,
	output logic                          run_last,
	output logic                          image_last
);

	logic                              active_q;
	xrle_pkg::cmd_t                    cmd_q;
	logic [xrle_pkg::COUNT_W-1:0]      count_q;
	logic [xrle_pkg::PAIRS_W-1:0]      pairs_done_q;
	logic [xrle_pkg::PAIRS_W-1:0]      pairs_next;
	logic                              out_valid_q;
	logic                              step;
	logic                              img_full;
	logic                              fill;
	logic                              cmd_last;
	logic                              emit;

	assign q_pop      = !active_q && !q_empty;
	assign step       = active_q && (!out_valid_q || out_ready);
	assign img_full   = (pairs_done_q >= total_pairs);
	assign pairs_next = pairs_done_q + 1'b1;
	assign fill       = (pairs_next == total_pairs);
	assign cmd_last   = (count_q == xrle_pkg::COUNT_W'(1));
	assign emit       = step && !img_full;
	assign out_valid  = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q     <= 1'b0;
			count_q      <= '0;
			pairs_done_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_ready) out_valid_q <= 1'b0;
			if (q_pop) begin
				active_q <= 1'b1;
				count_q  <= q_cmd.count;
			end else if (step) begin
				if (img_full) begin
					// image already full: drop the rest of this command
					active_q <= 1'b0;
					if (cmd_q.run_end) pairs_done_q <= '0;
				end else begin
					out_valid_q <= 1'b1;
					count_q     <= count_q - 1'b1;
					if (cmd_last) active_q <= 1'b0;
					if (cmd_last && cmd_q.run_end && fill) begin
						pairs_done_q <= '0;
					end else begin
						pairs_done_q <= pairs_next;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_cmd;
		end
		if (emit) begin
			char_code  <= cmd_q.char_code;
			attribute  <= cmd_q.attribute;
			run_last   <= cmd_last || fill;
			image_last <= fill;
		end
	end

endmodule

// ----- hdl/xbin_rle_pair_decoder_top.sv -----
// ----------------------------------------------------------------------------
// xbin_rle_pair_decoder_top
// Run-length decoder for text-mode images: compressed bytes in,
// character/attribute pairs out.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  (in_valid/in_ready, data_byte): one compressed byte per
//   transaction. Header, mode-0 character and repeat bytes give no pair,
//   save the mode-3 repeat attribute byte, which gives the whole run.
//   out channel (out_valid/out_ready): one pair per transaction, run_last on
//   the last pair a byte causes, image_last on the pair that fills the image.
//   cfg channel (cfg_valid/cfg_ready, cfg_data): image size in pairs; write
//   only while idle. cfg_ready is always high.
//   Throughput: a byte is taken each cycle while the four-entry command queue
//   has room; the emitter loads one command at a time and emits its pairs
//   one per cycle while out_ready allows, loading the next command only
//   after the last pair of the current one.
//   Pairs past the image size are dropped; the count restarts at the end of
//   the run that filled the image.
//   Reset clears parser, queue and pair count; image size returns to 2000.
//   A stalled receiver holds the output register; the queue absorbs up to
//   four more commands before in_ready drops.
// ----------------------------------------------------------------------------
module xbin_rle_pair_decoder_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [23:0] cfg_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  char_code,
	output logic [7:0]  attribute,
	output logic        run_last,
	output logic        image_last
);

	logic [xrle_pkg::PAIRS_W-1:0]  total_pairs_q;
	logic                          q_push;
	logic                          q_pop;
	logic                          q_full;
	logic                          q_empty;
	xrle_pkg::cmd_t                push_cmd;
	xrle_pkg::cmd_t                pop_cmd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_pairs_q <= xrle_pkg::TOTAL_PAIRS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			total_pairs_q <= cfg_data;
		end
	end

	xrle_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_cmd     (push_cmd)
	);

	xrle_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.pop      (q_pop),
		.pop_cmd  (pop_cmd),
		.full     (q_full),
		.empty    (q_empty)
	);

	xrle_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_cmd       (pop_cmd),
		.q_pop       (q_pop),
		.total_pairs (total_pairs_q),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.char_code   (char_code),
		.attribute   (attribute),
		.run_last    (run_last),
		.image_last  (image_last)
	);

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && q_full))
		else $error("command pushed into full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("command popped from empty queue");

	a_image_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && image_last) |-> run_last)
		else $error("image_last without run_last");

	a_push_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> (in_valid && in_ready))
		else $error("command pushed without an input transaction");

endmodule
